// ===== hw/rtl/afdc_pkg.sv =====
// Shared types and constants for the audio FIFO drift compensator.
// Used by the top level, the port checker and the testbench.
package afdc_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 4096;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned BF_W     = 12;
  localparam int unsigned TGT_W    = BF_W + 1;
  localparam int unsigned LIM_W    = BF_W + 2;
  localparam int unsigned BP_W     = 24;
  localparam int unsigned DS_W     = 16;
  localparam int unsigned CORR_W   = 24;
  localparam int unsigned PERIOD_W = 25;
  localparam int unsigned PHASE_W  = 26;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 40;

  // Reset values of the configuration registers and derived values.
  localparam logic [TGT_W-1:0]    TARGET_RST = TGT_W'(1764);
  localparam logic [LIM_W-1:0]    LIMIT_RST  = LIM_W'(1940);
  localparam logic [BP_W-1:0]     BASE_RST   = BP_W'(5192942);
  localparam logic [DS_W-1:0]     STEP_RST   = DS_W'(655);

  // Reciprocal of ten for 16-bit operands: x / 10 == (x * 52429) >> 19.
  localparam logic [15:0] TENTH_MUL = 16'd52429;
  localparam int unsigned TENTH_SHR = 19;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH = 2'd0,
    REQ_TICK = 2'd1,
    REQ_POP  = 2'd2
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_FRAMES = 2'd0,
    CFG_BASE_PERIOD  = 2'd1,
    CFG_DELTA_STEP   = 2'd2
  } cfg_idx_e;

  // Status of the word waiting on the RAM read.
  typedef struct packed {
    logic valid;
    logic due;
    logic left_ok;
    logic right_ok;
  } rd_stage_t;

endpackage

// ===== hw/rtl/afdc_ram.sv =====
// Generic synchronous RAM: one write port, two read ports, registered read data.
// Standalone; no package dependency.
module afdc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== hw/rtl/audio_fifo_drift_compensator_unit.sv =====
// Audio FIFO with fill-level feedback on the sample period divider.
// Depends on afdc_pkg and afdc_ram.
//
//  channel   dir  tdata / data                         tuser      tlast
//  s_axis    in   [15:0] sample                        req_type   last_of_block
//  m_axis    out  [0] sample_due [16:1] left           -          -
//                 [32:17] right [39:33] zero
//  cfg       in   cfg_index_i, cfg_data_i (24 bit)     -          -
//
// One item per clock while s_axis_tready is high. A pop reads both samples of its
// frame from the RAM in the cycle it is accepted; the word moves on into the output
// register once that register is free. Pointers, fill level, correction, period and
// phase live in flops and are updated at acceptance, so back-to-back items see them.
// No clearing pass after reset; sample RAM data is only used where written.
// s_axis_tready drops only while the read stage and the output register are both
// full and m_axis_tready is low.
module audio_fifo_drift_compensator_unit #(
  parameter int unsigned FIFO_DEPTH = afdc_pkg::FIFO_DEPTH_DEF,
  parameter int unsigned FRAC_BITS  = afdc_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [afdc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [15:0] sample
  input  logic [afdc_pkg::REQ_W-1:0]         s_axis_tuser,   // [1:0] req_type
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [afdc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // [0] due [16:1] L [32:17] R
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [afdc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [afdc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned PTR_W  = $clog2(FIFO_DEPTH);
  localparam int unsigned FILL_W = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned CMP_W  = (FILL_W > 15) ? FILL_W + 1 : 16;
  localparam int unsigned PH_W   = afdc_pkg::PHASE_W + 2;
  localparam int unsigned CS_W   = afdc_pkg::CORR_W + 1;
  localparam int unsigned PS_W   = afdc_pkg::PERIOD_W + 1;
  localparam int unsigned SW     = afdc_pkg::SAMPLE_W;

  localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(FIFO_DEPTH);
  localparam logic [CMP_W-1:0]  DEPTH_CMP  = CMP_W'(FIFO_DEPTH);
  localparam logic signed [PH_W-1:0] ONE_FIX = PH_W'(1) << FRAC_BITS;
  localparam logic signed [PH_W-1:0] PH_MAX  = PH_W'((1 << (afdc_pkg::PHASE_W - 1)) - 1);
  localparam logic signed [PH_W-1:0] PH_MIN  = -PH_W'(1 << (afdc_pkg::PHASE_W - 1));
  localparam logic signed [CS_W-1:0] C_MAX   = CS_W'((1 << (afdc_pkg::CORR_W - 1)) - 1);
  localparam logic signed [CS_W-1:0] C_MIN   = -CS_W'(1 << (afdc_pkg::CORR_W - 1));
  localparam logic signed [PS_W-1:0] P_MAX   = PS_W'((1 << afdc_pkg::PERIOD_W) - 1);

  // Configuration registers; target and its 110% limit are derived at write time.
  logic [afdc_pkg::TGT_W-1:0]  target_q;
  logic [afdc_pkg::LIM_W-1:0]  limit_q;
  logic [afdc_pkg::BP_W-1:0]   base_q;
  logic [afdc_pkg::DS_W-1:0]   step_q;
  logic [afdc_pkg::TGT_W-1:0]  cfg_tgt;
  logic [afdc_pkg::TGT_W+15:0] cfg_prod;
  logic [afdc_pkg::LIM_W-1:0]  cfg_lim;

  assign cfg_ready_o = 1'b1;
  assign cfg_tgt  = {cfg_data_i[afdc_pkg::BF_W-1:0], 1'b0};
  assign cfg_prod = (afdc_pkg::TGT_W + 16)'(cfg_tgt) * (afdc_pkg::TGT_W + 16)'(afdc_pkg::TENTH_MUL);
  assign cfg_lim  = afdc_pkg::LIM_W'(cfg_tgt) + afdc_pkg::LIM_W'(cfg_prod >> afdc_pkg::TENTH_SHR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= afdc_pkg::TARGET_RST;
      limit_q  <= afdc_pkg::LIMIT_RST;
      base_q   <= afdc_pkg::BASE_RST;
      step_q   <= afdc_pkg::STEP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (afdc_pkg::cfg_idx_e'(cfg_index_i))
        afdc_pkg::CFG_BLOCK_FRAMES: begin
          target_q <= cfg_tgt;
          limit_q  <= cfg_lim;
        end
        afdc_pkg::CFG_BASE_PERIOD: base_q <= cfg_data_i[afdc_pkg::BP_W-1:0];
        afdc_pkg::CFG_DELTA_STEP:  step_q <= cfg_data_i[afdc_pkg::DS_W-1:0];
        default: ;
      endcase
    end
  end

  // FIFO and timing state.
  logic [PTR_W-1:0]  rp_q, rp_d, wp_q, wp_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic signed [afdc_pkg::CORR_W-1:0]  corr_q, corr_d;
  logic [afdc_pkg::PERIOD_W-1:0]       period_q, period_d;
  logic signed [afdc_pkg::PHASE_W-1:0] phase_q, phase_d;

  afdc_pkg::rd_stage_t rd_q, rd_d;
  logic                       out_valid_q;
  logic [afdc_pkg::OUT_TDATA_W-1:0] out_data_q;
  logic                       advance;
  logic                       accept;
  afdc_pkg::req_e             req;

  logic [SW-1:0] rdata_a, rdata_b;
  logic          mem_we, mem_re;
  logic [PTR_W-1:0] rp_next, rp_next2;

  assign advance       = rd_q.valid && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !rd_q.valid || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign req           = afdc_pkg::req_e'(s_axis_tuser);

  assign rp_next  = (rp_q == PTR_LAST) ? '0 : rp_q + PTR_W'(1);
  assign rp_next2 = (rp_next == PTR_LAST) ? '0 : rp_next + PTR_W'(1);

  assign mem_we = accept && (req == afdc_pkg::REQ_PUSH) && (fill_q < FILL_FULL);
  assign mem_re = accept && (req == afdc_pkg::REQ_POP);

  // A write lands at its acceptance edge and a pop reads at its own later edge,
  // so a pop always sees the pushes before it without forwarding.
  afdc_ram #(
    .WIDTH (SW),
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (wp_q),
    .wdata_i   (s_axis_tdata[SW-1:0]),
    .re_i      (mem_re),
    .raddr_a_i (rp_q),
    .raddr_b_i (rp_next),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Pop: fill after taking the frame, then block-end feedback.
  logic [CMP_W-1:0] fill_after, tgt_c, trim_base;
  logic             two_ok;
  logic signed [CS_W-1:0] c_ext, c_up, c_dn, c_sel;
  logic signed [PS_W:0]   p_sum;
  logic [afdc_pkg::PERIOD_W-1:0] p_sat;
  logic signed [afdc_pkg::CORR_W-1:0] corr_blk;

  assign two_ok     = fill_q >= FILL_W'(2);
  assign fill_after = two_ok ? CMP_W'(fill_q) - CMP_W'(2) : '0;
  assign tgt_c      = CMP_W'(target_q);
  assign trim_base  = (CMP_W'(wp_q) >= tgt_c) ? CMP_W'(wp_q) : CMP_W'(wp_q) + DEPTH_CMP;

  always_comb begin
    c_ext = CS_W'(corr_q);
    c_up  = ((c_ext < 0) ? CS_W'(0) : c_ext) + CS_W'(step_q);
    c_dn  = ((c_ext > 0) ? CS_W'(0) : c_ext) - CS_W'(step_q);
    if (c_up > C_MAX) c_up = C_MAX;
    if (c_dn < C_MIN) c_dn = C_MIN;
    if (fill_after > tgt_c) begin
      c_sel = c_up;
    end else if (fill_after < tgt_c) begin
      c_sel = c_dn;
    end else begin
      c_sel = '0;
    end
    // Overfull: keep only the newest target samples and drop the correction.
    if (fill_after > CMP_W'(limit_q)) begin
      c_sel = '0;
    end
    corr_blk = afdc_pkg::CORR_W'(c_sel);
    p_sum = (PS_W + 1)'(signed'({1'b0, base_q})) + (PS_W + 1)'(corr_blk);
    if (p_sum < 0) begin
      p_sat = '0;
    end else if (p_sum > (PS_W + 1)'(P_MAX)) begin
      p_sat = P_MAX[afdc_pkg::PERIOD_W-1:0];
    end else begin
      p_sat = afdc_pkg::PERIOD_W'(p_sum);
    end
  end

  // Tick: fractional divider.
  logic signed [PH_W-1:0] ph_sub, ph_new;
  logic                   tick_due;

  always_comb begin
    ph_sub   = PH_W'(phase_q) - ONE_FIX;
    tick_due = (ph_sub <= 0);
    ph_new   = tick_due ? ph_sub + PH_W'(signed'({1'b0, period_q})) : ph_sub;
    if (ph_new > PH_MAX) ph_new = PH_MAX;
    if (ph_new < PH_MIN) ph_new = PH_MIN;
  end

  always_comb begin
    rp_d     = rp_q;
    wp_d     = wp_q;
    fill_d   = fill_q;
    corr_d   = corr_q;
    period_d = period_q;
    phase_d  = phase_q;
    rd_d     = rd_q;
    if (advance) begin
      rd_d.valid = 1'b0;
    end
    if (accept) begin
      case (req)
        afdc_pkg::REQ_PUSH: begin
          if (mem_we) begin
            wp_d   = (wp_q == PTR_LAST) ? '0 : wp_q + PTR_W'(1);
            fill_d = fill_q + FILL_W'(1);
          end
        end
        afdc_pkg::REQ_TICK: begin
          phase_d = afdc_pkg::PHASE_W'(ph_new);
          rd_d    = '{valid: 1'b1, due: tick_due, left_ok: 1'b0, right_ok: 1'b0};
        end
        afdc_pkg::REQ_POP: begin
          rd_d = '{valid: 1'b1, due: 1'b0, left_ok: (fill_q != '0), right_ok: two_ok};
          if (two_ok) begin
            rp_d   = rp_next2;
            fill_d = fill_q - FILL_W'(2);
          end else begin
            rp_d   = wp_q;
            fill_d = '0;
          end
          if (s_axis_tlast) begin
            corr_d   = corr_blk;
            period_d = p_sat;
            if (fill_after > CMP_W'(limit_q)) begin
              rp_d   = PTR_W'(trim_base - tgt_c);
              fill_d = FILL_W'(target_q);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q        <= '0;
      wp_q        <= '0;
      fill_q      <= '0;
      corr_q      <= '0;
      period_q    <= afdc_pkg::PERIOD_W'(afdc_pkg::BASE_RST);
      phase_q     <= '0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rp_q     <= rp_d;
      wp_q     <= wp_d;
      fill_q   <= fill_d;
      corr_q   <= corr_d;
      period_q <= period_d;
      phase_q  <= phase_d;
      rd_q     <= rd_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {7'd0,
                     rd_q.right_ok ? rdata_b : SW'(0),
                     rd_q.left_ok  ? rdata_a : SW'(0),
                     rd_q.due};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== hw/rtl/afdc_checker.sv =====
// Port-level checker for the audio FIFO drift compensator, bound to the top level.
// Depends on afdc_pkg for port widths.
module afdc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [afdc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // A stalled word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // Pad bits above the right sample are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[39:33] == 7'd0)
    else $error("nonzero pad bits in output word");

  // A tick word that raises sample_due carries no audio.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[32:1] == 32'd0)
    else $error("sample_due word carries audio");

  // Input side stalls only while the output side is full and stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

endmodule

bind audio_fifo_drift_compensator_unit afdc_checker u_afdc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== test/tb_audio_fifo_drift_compensator_unit.sv =====
// Self-checking testbench for the audio FIFO drift compensator top level.
// Needs afdc_pkg and the RTL of audio_fifo_drift_compensator_unit; it predicts
// every output word and checks it in order.
`timescale 1ns / 100ps

module tb_audio_fifo_drift_compensator_unit;

  localparam int unsigned FIFO_WORDS   = afdc_pkg::FIFO_DEPTH_DEF;
  localparam longint      ONE_TICK     = longint'(1) << afdc_pkg::FRAC_BITS_DEF;
  localparam longint      CORR_MAX     = 64'sd8388607;
  localparam longint      CORR_MIN     = -64'sd8388608;
  localparam longint      PERIOD_MAX   = 64'sd33554431;
  localparam longint      PHASE_MAX    = 64'sd33554431;
  localparam longint      PHASE_MIN    = -64'sd33554432;
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          DIR_ROWS     = 22;
  localparam int          TRAFFIC_RUN  = 35;

  typedef struct packed {
    logic               due;
    logic signed [15:0] left;
    logic signed [15:0] right;
  } frame_t;

  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] smp;
    logic        lst;
    logic        typed_ok;
    frame_t      want;
  } dir_row_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [afdc_pkg::IN_TDATA_W-1:0]  s_axis_tdata;   // [15:0] sample
  logic [afdc_pkg::REQ_W-1:0]       s_axis_tuser;   // [1:0] req_type
  logic                             s_axis_tlast;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [afdc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // [0] sample_due [16:1] left [32:17] right
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [afdc_pkg::CFG_IDX_W-1:0]   cfg_index_i;
  logic [afdc_pkg::CFG_DATA_W-1:0]  cfg_data_i;

  // Shadow copy of the block state and its registers.
  logic [15:0]        sample_mem [FIFO_WORDS];
  int unsigned        rd_idx;
  int unsigned        wr_idx;
  int unsigned        fill_cnt;
  logic signed [23:0] corr_acc;
  logic [24:0]        period_cur;
  logic signed [25:0] phase_acc;
  logic [11:0]        cfg_block_frames;
  logic [23:0]        cfg_base_period;
  logic [15:0]        cfg_delta_step;

  frame_t   pending_frames [$];
  frame_t   seen_frame;
  frame_t   want_frame;
  dir_row_t dir_rows [DIR_ROWS];

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int stall_cycles  = 0;
  int mismatches    = 0;
  int items_sent    = 0;
  int frames_seen   = 0;
  int blocks_closed = 0;
  int reg_writes    = 0;

  audio_fifo_drift_compensator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] take_word();
    logic [15:0] w;
    w = sample_mem[rd_idx];
    rd_idx = (rd_idx + 1) % FIFO_WORDS;
    fill_cnt--;
    return w;
  endfunction

  // Fill-level feedback applied on the last frame of a sink block.
  task automatic close_block();
    int unsigned target;
    longint c;
    longint p;
    target = 2 * cfg_block_frames;
    c = longint'(corr_acc);
    if (fill_cnt > target) begin
      if (c < 0) c = 0;
      c += longint'(cfg_delta_step);
    end else if (fill_cnt < target) begin
      if (c > 0) c = 0;
      c -= longint'(cfg_delta_step);
    end else begin
      c = 0;
    end
    if (c > CORR_MAX) c = CORR_MAX;
    if (c < CORR_MIN) c = CORR_MIN;
    corr_acc = c[23:0];
    if (fill_cnt > target + target / 10) begin
      rd_idx   = (wr_idx + FIFO_WORDS - target) % FIFO_WORDS;
      fill_cnt = target;
      corr_acc = '0;
    end
    p = longint'(cfg_base_period) + longint'(corr_acc);
    if (p < 0) p = 0;
    if (p > PERIOD_MAX) p = PERIOD_MAX;
    period_cur = p[24:0];
    blocks_closed++;
  endtask

  task automatic predict_item(input logic [1:0] req, input logic [15:0] smp,
                              input logic lst, output logic has_frame,
                              output frame_t frame);
    longint ph;
    has_frame = 1'b0;
    frame     = '0;
    case (req)
      afdc_pkg::REQ_PUSH: begin
        if (fill_cnt < FIFO_WORDS) begin
          sample_mem[wr_idx] = smp;
          wr_idx = (wr_idx + 1) % FIFO_WORDS;
          fill_cnt++;
        end
      end
      afdc_pkg::REQ_TICK: begin
        has_frame = 1'b1;
        ph = longint'(phase_acc) - ONE_TICK;
        if (ph <= 0) begin
          ph += longint'(period_cur);
          frame.due = 1'b1;
        end
        if (ph > PHASE_MAX) ph = PHASE_MAX;
        if (ph < PHASE_MIN) ph = PHASE_MIN;
        phase_acc = ph[25:0];
      end
      afdc_pkg::REQ_POP: begin
        has_frame = 1'b1;
        if (fill_cnt >= 2) begin
          frame.left  = take_word();
          frame.right = take_word();
        end else begin
          // A lone sample goes out on the left; an underrun empties the FIFO.
          if (fill_cnt == 1) frame.left = take_word();
          rd_idx   = wr_idx;
          fill_cnt = 0;
        end
        if (lst) close_block();
      end
      default: ;
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic [1:0] req, input logic [15:0] smp, input logic lst,
                           input logic typed_ok, input frame_t typed);
    logic   has_frame;
    frame_t frame;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= smp;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_item(req, smp, lst, has_frame, frame);
    if (has_frame) pending_frames.insert(pending_frames.size(), typed_ok ? typed : frame);
    if (req != REQ_UNUSED) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send(input logic [1:0] req, input logic [15:0] smp, input logic lst);
    send_item(req, smp, lst, 1'b0, '0);
  endtask

  // Pushes leave no word behind, so the bench keeps waiting after the last result.
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input afdc_pkg::cfg_idx_e idx, input logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      afdc_pkg::CFG_BLOCK_FRAMES: cfg_block_frames = data[11:0];
      afdc_pkg::CFG_BASE_PERIOD:  cfg_base_period  = data;
      afdc_pkg::CFG_DELTA_STEP:   cfg_delta_step   = data[15:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
  endtask

  task automatic configure(input int bf, input int base, input int step);
    quiesce();
    write_reg(afdc_pkg::CFG_BLOCK_FRAMES, 24'(bf));
    write_reg(afdc_pkg::CFG_BASE_PERIOD, 24'(base));
    write_reg(afdc_pkg::CFG_DELTA_STEP, 24'(step));
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly source/sink traffic that keeps the fill level near its target,
  // with bursts that overshoot it and some noise.
  task automatic run_traffic(input int n_items);
    int         sent;
    int         pops_in_block;
    int         roll;
    int         burst;
    logic [1:0] req;
    sent = 0;
    pops_in_block = 0;
    while (sent < n_items) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        req = 2'($urandom_range(3));
        send(req, 16'($urandom), 1'($urandom_range(1)));
        if (req != REQ_UNUSED) sent++;
      end else if (roll < 11) begin
        burst = $urandom_range(1, 3 * cfg_block_frames);
        repeat (burst) send(afdc_pkg::REQ_PUSH, 16'($urandom), 1'b0);
        sent += burst;
      end else if (roll < 30) begin
        send(afdc_pkg::REQ_TICK, 16'($urandom), 1'($urandom_range(1)));
        sent++;
      end else if (roll < ((fill_cnt < 2 * cfg_block_frames) ? 86 : 65)) begin
        send(afdc_pkg::REQ_PUSH, 16'($urandom), 1'b0);
        sent++;
      end else begin
        pops_in_block++;
        send(afdc_pkg::REQ_POP, 16'($urandom), pops_in_block >= cfg_block_frames);
        if (pops_in_block >= cfg_block_frames) pops_in_block = 0;
        sent++;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] seen);
    $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, seen);
    mismatches++;
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      frames_seen++;
      seen_frame.due   = m_axis_tdata[0];
      seen_frame.left  = m_axis_tdata[16:1];
      seen_frame.right = m_axis_tdata[32:17];
      if (pending_frames.size() == 0) begin
        report_mismatch("unexpected word", '0, m_axis_tdata[15:0]);
      end else begin
        want_frame = pending_frames.pop_front();
        if (seen_frame.due !== want_frame.due)
          report_mismatch("sample_due", want_frame.due, seen_frame.due);
        if (seen_frame.left !== want_frame.left)
          report_mismatch("left_sample", want_frame.left, seen_frame.left);
        if (seen_frame.right !== want_frame.right)
          report_mismatch("right_sample", want_frame.right, seen_frame.right);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no word moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_frames.size());
        $display("FAIL audio_fifo_drift_compensator_unit");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = afdc_pkg::CFG_BLOCK_FRAMES;
    cfg_data_i    = '0;

    rd_idx           = 0;
    wr_idx           = 0;
    fill_cnt         = 0;
    corr_acc         = '0;
    phase_acc        = '0;
    cfg_block_frames = 12'(afdc_pkg::TARGET_RST >> 1);
    cfg_base_period  = afdc_pkg::BASE_RST;
    cfg_delta_step   = afdc_pkg::STEP_RST;
    period_cur       = 25'(afdc_pkg::BASE_RST);

    // Expected words are typed in where they follow directly from reset state.
    dir_rows = '{
      '{afdc_pkg::REQ_POP,  16'h0000, 1'b0, 1'b1, {1'b0, 16'h0000, 16'h0000}},
      '{afdc_pkg::REQ_TICK, 16'h0000, 1'b0, 1'b1, {1'b1, 16'h0000, 16'h0000}},
      '{afdc_pkg::REQ_TICK, 16'hFFFF, 1'b0, 1'b1, {1'b0, 16'h0000, 16'h0000}},
      '{afdc_pkg::REQ_PUSH, 16'h7FFF, 1'b0, 1'b0, '0},
      '{afdc_pkg::REQ_PUSH, 16'h8000, 1'b0, 1'b0, '0},
      '{afdc_pkg::REQ_POP,  16'h0000, 1'b0, 1'b1, {1'b0, 16'h7FFF, 16'h8000}},
      '{afdc_pkg::REQ_PUSH, 16'hFFFF, 1'b0, 1'b0, '0},
      '{afdc_pkg::REQ_POP,  16'h0000, 1'b0, 1'b1, {1'b0, 16'hFFFF, 16'h0000}},
      '{afdc_pkg::REQ_POP,  16'h0000, 1'b1, 1'b1, {1'b0, 16'h0000, 16'h0000}},
      '{REQ_UNUSED,         16'h1234, 1'b1, 1'b0, '0},
      '{afdc_pkg::REQ_PUSH, 16'h0000, 1'b0, 1'b0, '0},
      '{afdc_pkg::REQ_PUSH, 16'h5555, 1'b0, 1'b0, '0},
      '{afdc_pkg::REQ_PUSH, 16'hAAAA, 1'b0, 1'b0, '0},
      '{afdc_pkg::REQ_POP,  16'h0000, 1'b0, 1'b1, {1'b0, 16'h0000, 16'h5555}},
      '{afdc_pkg::REQ_POP,  16'h0000, 1'b1, 1'b1, {1'b0, 16'hAAAA, 16'h0000}},
      '{afdc_pkg::REQ_TICK, 16'h0000, 1'b0, 1'b0, '0},
      '{afdc_pkg::REQ_PUSH, 16'h0001, 1'b0, 1'b0, '0},
      '{afdc_pkg::REQ_PUSH, 16'h0002, 1'b0, 1'b0, '0},
      '{afdc_pkg::REQ_POP,  16'h0000, 1'b0, 1'b1, {1'b0, 16'h0001, 16'h0002}},
      '{afdc_pkg::REQ_TICK, 16'h0000, 1'b1, 1'b0, '0},
      '{afdc_pkg::REQ_PUSH, 16'h4000, 1'b1, 1'b0, '0},
      '{afdc_pkg::REQ_POP,  16'h0000, 1'b0, 1'b1, {1'b0, 16'h4000, 16'h0000}}
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    src_idle_pct  = 25;
    sink_idle_pct = 73;
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].req, dir_rows[i].smp, dir_rows[i].lst,
                dir_rows[i].typed_ok, dir_rows[i].want);
    end

    configure($urandom_range(4, 16), $urandom_range(65536, 400000), $urandom_range(1, 65535));
    run_traffic(TRAFFIC_RUN);
    configure(1, 16777215, 1);
    run_traffic(TRAFFIC_RUN);

    src_idle_pct  = 73;
    sink_idle_pct = 25;
    configure($urandom_range(1, 64), $urandom_range(65536, 16777215),
              $urandom_range(1, 65535));
    run_traffic(TRAFFIC_RUN);
    // A short period here keeps the phase low before the divider test below.
    configure($urandom_range(1, 64), $urandom_range(65536, 400000),
              $urandom_range(1, 1000));
    run_traffic(TRAFFIC_RUN);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    // A target equal to the FIFO depth with the largest step: the correction runs into its
    // negative limit, the period clamps at zero, and the phase at its floor.
    configure(2048, 65536, 65535);
    repeat (135) send(afdc_pkg::REQ_POP, 16'($urandom), 1'b1);
    repeat (530) send(afdc_pkg::REQ_TICK, 16'($urandom), 1'b0);
    // A fill one above a small target drives the correction into its positive
    // limit; a final overshoot trims the FIFO to its target and clears the correction.
    configure(10, $urandom_range(65536, 16777215), 65535);
    repeat (23) send(afdc_pkg::REQ_PUSH, 16'($urandom), 1'b0);
    send(afdc_pkg::REQ_POP, 16'($urandom), 1'b1);
    repeat (130) begin
      send(afdc_pkg::REQ_PUSH, 16'($urandom), 1'b0);
      send(afdc_pkg::REQ_PUSH, 16'($urandom), 1'b0);
      send(afdc_pkg::REQ_POP, 16'($urandom), 1'b1);
    end
    repeat (10) send(afdc_pkg::REQ_PUSH, 16'($urandom), 1'b0);
    send(afdc_pkg::REQ_POP, 16'($urandom), 1'b1);

    quiesce();
    $display("Run covered %0d input words and %0d output words,", items_sent, frames_seen);
    $display("with %0d block ends and %0d register writes.", blocks_closed, reg_writes);
    if (mismatches == 0) begin
      $display("PASS audio_fifo_drift_compensator_unit");
    end else begin
      $display("%0d mismatches found", mismatches);
      $display("FAIL audio_fifo_drift_compensator_unit");
    end
    $finish;
  end

endmodule
